// File: hw/rtl/sfa_pkg.sv
`timescale 1ns / 1ps

package sfa_pkg;

    localparam int SLOT_W   = 6;
    localparam int OFFSET_W = 15;
    localparam int LIVE_W   = 16;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_FIXED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REUSE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_RESULT
    } sfa_state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_CLEAR
    } sfa_op_t;

    typedef struct packed {
        sfa_op_t op;
        logic    cls;
    } sfa_cmd_t;

endpackage

// File: hw/rtl/sfa_cell.sv
`timescale 1ns / 1ps

module sfa_cell
    import sfa_pkg::*;
#(
    parameter int IW  = 16,
    parameter int XW  = 6,
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfa_cmd_t          cmd,
    input  logic [XW-1:0]     cmd_idx,
    input  logic [IW-1:0]     wr_start,
    input  logic [IW-1:0]     wr_end,
    input  logic [LIVE_W-1:0] probe_start,
    input  logic              tok_shift,
    input  logic              tok_clear,
    input  logic              tok_in,
    output logic              tok_out,
    output logic              hit
);

    localparam int CW = (IW > LIVE_W) ? IW : LIVE_W;

    logic [IW-1:0] start_reg [2];
    logic [IW-1:0] end_reg [2];
    logic          busy_reg [2];
    logic          tok_reg;
    logic          tok_next;
    logic          sel;

    assign sel = (cmd_idx == XW'(IDX));

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_WRITE:
            begin
                if (sel)
                begin
                    start_reg[cmd.cls] <= wr_start;
                    end_reg[cmd.cls]   <= wr_end;
                    busy_reg[cmd.cls]  <= 1'b1;
                end
            end
            OP_CLEAR:
            begin
                if (sel)
                begin
                    busy_reg[cmd.cls] <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        tok_next = tok_reg;
        if (tok_clear)
        begin
            tok_next = 1'b0;
        end
        else if (tok_shift)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    // free, or interval over by the new start
    assign hit = tok_reg &&
                 (!busy_reg[cmd.cls] || (CW'(end_reg[cmd.cls]) <= CW'(probe_start)));

endmodule

// File: hw/rtl/spill_slot_first_fit_allocator_unit.sv
`timescale 1ns / 1ps
// Spill slot allocator: two slot tables (gpr, vec), first-fit reuse.
// Input channel s_*: one request per transfer. s_tuser = kind, reg_class;
// s_tdata = has_slot, prior_slot, live_start, live_end, release_slot.
// Output channel m_*: exactly one result per request, in order.
// m_tdata = slot_number, frame_offset; m_tuser = was_reused, was_appended,
// table_full.
// Fixed, release, owned and unused requests go from ST_DECIDE straight
// to ST_RESULT; a reuse request with a non-empty table scans it one cell
// per cycle from cell 0 up to the first fit, or through all filled cells
// when none fits. One request is in flight at a time and the next is
// taken in ST_IDLE, after its result is loaded into the output register.
// The scan token walks the row of cells, one entry per cycle.
// Reset empties both tables (fill counts zero) and the output register.
// When the receiver stalls, the result waits in the output register; the
// next request is accepted meanwhile and its result waits until that
// register frees.
module spill_slot_first_fit_allocator_unit
    import sfa_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int INDEX_BITS = 16,
    parameter int SLOT_BIAS  = 1000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] has_slot, [6:1] prior_slot, [22:7] live_start, [38:23] live_end,
    // [44:39] release_slot, [47:45] zero
    input  logic [47:0] s_tdata,
    // [1:0] kind, [2] reg_class
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] slot_number, [20:6] frame_offset, [23:21] zero
    output logic [23:0] m_tdata,
    // [0] was_reused, [1] was_appended, [2] table_full
    output logic [2:0]  m_tuser
);

    localparam int XW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FW = $clog2(SLOT_COUNT + 1);
    localparam int IW = INDEX_BITS;

    sfa_state_t state_reg, state_next;

    logic [KIND_W-1:0] kind_reg;
    logic              cls_reg;
    logic              has_reg;
    logic [SLOT_W-1:0] prior_reg;
    logic [LIVE_W-1:0] lstart_reg;
    logic [LIVE_W-1:0] lend_reg;
    logic [SLOT_W-1:0] rel_reg;

    logic [FW-1:0] gpr_fill_reg, gpr_fill_next;
    logic [FW-1:0] vec_fill_reg, vec_fill_next;
    logic [XW-1:0] scan_reg, scan_next;

    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [OFFSET_W-1:0] res_off_reg, res_off_next;
    logic [2:0]          res_flag_reg, res_flag_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    logic        out_load;

    sfa_cmd_t      cmd;
    logic [XW-1:0] cmd_idx;
    logic [IW-1:0] wr_start;
    logic [IW-1:0] wr_end;
    logic          tok_shift;
    logic          tok_clear;
    logic          tok_first;
    logic          done;
    logic          start_scan;

    logic [SLOT_COUNT-1:0] tok_vec;
    logic [SLOT_COUNT-1:0] hit_vec;
    logic                  any_hit;
    logic [FW-1:0]         fill_sel;
    logic [31:0]           res_src;
    logic                  res_valid;
    logic [31:0]           mag;

    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++)
        begin : g_cell
            sfa_cell #(
                .IW  (IW),
                .XW  (XW),
                .IDX (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .cmd_idx     (cmd_idx),
                .wr_start    (wr_start),
                .wr_end      (wr_end),
                .probe_start (lstart_reg),
                .tok_shift   (tok_shift),
                .tok_clear   (tok_clear),
                .tok_in      ((gi == 0) ? tok_first : tok_vec[(gi == 0) ? 0 : gi - 1]),
                .tok_out     (tok_vec[gi]),
                .hit         (hit_vec[gi])
            );
        end
    endgenerate

    assign any_hit  = |hit_vec;
    assign fill_sel = cls_reg ? vec_fill_reg : gpr_fill_reg;
    assign mag      = (res_src + 32'(SLOT_BIAS) + 32'd1) << 3;

    // datapath and control outputs
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        cmd.op        = OP_NONE;
        cmd.cls       = cls_reg;
        cmd_idx       = fill_sel[XW-1:0];
        wr_start      = IW'(lstart_reg);
        wr_end        = IW'(lend_reg);
        tok_shift     = 1'b0;
        tok_clear     = 1'b0;
        tok_first     = 1'b0;
        done          = 1'b0;
        start_scan    = 1'b0;
        scan_next     = scan_reg;
        gpr_fill_next = gpr_fill_reg;
        vec_fill_next = vec_fill_reg;
        res_src       = 32'd0;
        res_valid     = 1'b0;
        res_flag_next = res_flag_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_DECIDE:
            begin
                done          = 1'b1;
                res_flag_next = 3'b000;
                if (kind_reg == KIND_RELEASE)
                begin
                    if (32'(rel_reg) < 32'(fill_sel))
                    begin
                        cmd.op  = OP_CLEAR;
                        cmd_idx = XW'(rel_reg);
                    end
                end
                else if (kind_reg != KIND_FIXED && kind_reg != KIND_REUSE)
                begin
                end
                else if (has_reg)
                begin
                    res_src   = 32'(prior_reg);
                    res_valid = 1'b1;
                end
                else if (kind_reg == KIND_REUSE && fill_sel != '0)
                begin
                    done       = 1'b0;
                    start_scan = 1'b1;
                    tok_shift  = 1'b1;
                    tok_first  = 1'b1;
                    scan_next  = '0;
                end
                else if (32'(fill_sel) < SLOT_COUNT)
                begin
                    cmd.op = OP_WRITE;
                    if (kind_reg == KIND_FIXED)
                    begin
                        wr_start = '0;
                        wr_end   = '1;
                    end
                    res_src       = 32'(fill_sel);
                    res_valid     = 1'b1;
                    res_flag_next = 3'b010;
                    if (cls_reg)
                        vec_fill_next = vec_fill_reg + FW'(1);
                    else
                        gpr_fill_next = gpr_fill_reg + FW'(1);
                end
                else
                begin
                    res_flag_next = 3'b100;
                end
            end
            ST_SCAN:
            begin
                if (any_hit)
                begin
                    done          = 1'b1;
                    tok_clear     = 1'b1;
                    cmd.op        = OP_WRITE;
                    cmd_idx       = scan_reg;
                    res_src       = 32'(scan_reg);
                    res_valid     = 1'b1;
                    res_flag_next = 3'b001;
                end
                else if (32'(scan_reg) + 32'd1 == 32'(fill_sel))
                begin
                    done      = 1'b1;
                    tok_clear = 1'b1;
                    if (32'(fill_sel) < SLOT_COUNT)
                    begin
                        cmd.op        = OP_WRITE;
                        res_src       = 32'(fill_sel);
                        res_valid     = 1'b1;
                        res_flag_next = 3'b010;
                        if (cls_reg)
                            vec_fill_next = vec_fill_reg + FW'(1);
                        else
                            gpr_fill_next = gpr_fill_reg + FW'(1);
                    end
                    else
                    begin
                        res_flag_next = 3'b100;
                    end
                end
                else
                begin
                    tok_shift = 1'b1;
                    scan_next = scan_reg + XW'(1);
                end
            end
            ST_RESULT:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
            end
        endcase

        res_slot_next = res_slot_reg;
        res_off_next  = res_off_reg;
        if (done)
        begin
            res_slot_next = res_valid ? res_src[SLOT_W-1:0] : '0;
            res_off_next  = res_valid ? OFFSET_W'(32'd0 - mag) : '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (start_scan)
                    state_next = ST_SCAN;
                else
                    state_next = ST_RESULT;
            end
            ST_SCAN:
            begin
                if (done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            gpr_fill_reg <= '0;
            vec_fill_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            gpr_fill_reg <= gpr_fill_next;
            vec_fill_reg <= vec_fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg   <= s_tuser[1:0];
            cls_reg    <= s_tuser[2];
            has_reg    <= s_tdata[0];
            prior_reg  <= s_tdata[6:1];
            lstart_reg <= s_tdata[22:7];
            lend_reg   <= s_tdata[38:23];
            rel_reg    <= s_tdata[44:39];
        end
        scan_reg     <= scan_next;
        res_slot_reg <= res_slot_next;
        res_off_reg  <= res_off_next;
        res_flag_reg <= res_flag_next;
        if (out_load)
        begin
            m_tdata_reg <= {3'b000, res_off_reg, res_slot_reg};
            m_tuser_reg <= res_flag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one scan token in the cell row");

    a_idle_no_tok: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (tok_vec == '0))
        else $error("scan token left behind after request completed");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(gpr_fill_reg) <= SLOT_COUNT) && (32'(vec_fill_reg) <= SLOT_COUNT))
        else $error("fill count beyond table size");

    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == 2'b00) && (m_tdata[20:0] == '0))
        else $error("table full result carries a slot");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sfa_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_BIAS   = 1000;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [LIVE_W-1:0] ENDLESS    = '1;
    localparam int RANDOM_REQUESTS = 1650;
    localparam int SINK_HOLD_AT    = 300;
    localparam int SINK_HOLD_LEN   = 400;
    localparam int DRAIN_AT        = 900;
    localparam int TAIL_CYCLES     = 80;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic              cls;
        logic              owned;
        logic [SLOT_W-1:0] prior;
        logic [LIVE_W-1:0] lstart;
        logic [LIVE_W-1:0] lend;
        logic [SLOT_W-1:0] rel;
    } spill_req_t;

    typedef struct {
        logic [SLOT_W-1:0]          slot;
        logic signed [OFFSET_W-1:0] offset;
        logic                       reused;
        logic                       appended;
        logic                       full;
    } slot_grant_t;

    class slot_grant_scoreboard;
        logic [LIVE_W-1:0] span_lo [2][TABLE_DEPTH];
        logic [LIVE_W-1:0] span_hi [2][TABLE_DEPTH];
        bit                busy    [2][TABLE_DEPTH];
        int unsigned       fill    [2];
        slot_grant_t       grants_due[$];
        int mismatches;
        int n_reused, n_appended, n_full, n_owned, n_released;

        function new();
            fill[0] = 0;
            fill[1] = 0;
            mismatches = 0;
            n_reused = 0;
            n_appended = 0;
            n_full = 0;
            n_owned = 0;
            n_released = 0;
        endfunction

        function logic signed [OFFSET_W-1:0] offset_of(int unsigned slot);
            int o;
            o = -((int'(slot) + SLOT_BIAS + 1) * 8);
            return o[OFFSET_W-1:0];
        endfunction

        function slot_grant_t granted(int unsigned slot, bit reused, bit appended);
            slot_grant_t g;
            g.slot     = slot[SLOT_W-1:0];
            g.offset   = offset_of(slot);
            g.reused   = reused;
            g.appended = appended;
            g.full     = 1'b0;
            return g;
        endfunction

        function slot_grant_t append_slot(int c, logic [LIVE_W-1:0] lo, logic [LIVE_W-1:0] hi);
            slot_grant_t g;
            g = '{default: '0};
            if (fill[c] >= TABLE_DEPTH)
            begin
                g.full = 1'b1;
                n_full++;
            end
            else
            begin
                span_lo[c][fill[c]] = lo;
                span_hi[c][fill[c]] = hi;
                busy[c][fill[c]]    = 1'b1;
                g = granted(fill[c], 1'b0, 1'b1);
                fill[c]++;
                n_appended++;
            end
            return g;
        endfunction

        function slot_grant_t grant_for(spill_req_t r);
            slot_grant_t g;
            int c;
            g = '{default: '0};
            c = int'(r.cls);
            if (r.kind == KIND_RELEASE)
            begin
                if (r.rel < fill[c])
                    busy[c][r.rel] = 1'b0;
                n_released++;
            end
            else if (r.kind == KIND_FIXED || r.kind == KIND_REUSE)
            begin
                if (r.owned)
                begin
                    g = granted(r.prior, 1'b0, 1'b0);
                    n_owned++;
                end
                else if (r.kind == KIND_FIXED)
                    g = append_slot(c, '0, ENDLESS);
                else
                begin
                    for (int i = 0; i < fill[c]; i++)
                    begin
                        if (!busy[c][i] || span_hi[c][i] <= r.lstart)
                        begin
                            span_lo[c][i] = r.lstart;
                            span_hi[c][i] = r.lend;
                            busy[c][i]    = 1'b1;
                            n_reused++;
                            return granted(i, 1'b1, 1'b0);
                        end
                    end
                    g = append_slot(c, r.lstart, r.lend);
                end
            end
            return g;
        endfunction

        function void note_request(spill_req_t r);
            grants_due = {grants_due, grant_for(r)};
        endfunction

        function void check_grant(logic [23:0] data, logic [2:0] user);
            slot_grant_t got, want;
            got.slot     = data[5:0];
            got.offset   = data[20:6];
            got.reused   = user[0];
            got.appended = user[1];
            got.full     = user[2];
            if (grants_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing outstanding: %s",
                             $time,
                             $sformatf("slot=%0d off=%0d r=%0b a=%0b f=%0b",
                                       got.slot, got.offset, got.reused,
                                       got.appended, got.full));
                return;
            end
            want = grants_due.pop_front();
            if (got.slot !== want.slot || got.offset !== want.offset ||
                got.reused !== want.reused || got.appended !== want.appended ||
                got.full !== want.full)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp %s, got %s", $time,
                             $sformatf("slot=%0d off=%0d r=%0b a=%0b f=%0b",
                                       want.slot, want.offset, want.reused,
                                       want.appended, want.full),
                             $sformatf("slot=%0d off=%0d r=%0b a=%0b f=%0b",
                                       got.slot, got.offset, got.reused,
                                       got.appended, got.full));
            end
        endfunction

        function int outstanding();
            return grants_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    slot_grant_scoreboard sb;
    int                   requests_sent;
    int                   src_mode;
    logic [LIVE_W-1:0]    pc_cursor [2];

    spill_slot_first_fit_allocator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    // 0: no gaps, 1: light, 2: heavy; mostly short gaps, occasionally long
    function int idle_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        return (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    endfunction

    function spill_req_t mk(logic [KIND_W-1:0] kind, logic cls, logic owned,
                            logic [SLOT_W-1:0] prior, logic [LIVE_W-1:0] lstart,
                            logic [LIVE_W-1:0] lend, logic [SLOT_W-1:0] rel);
        spill_req_t r;
        r.kind   = kind;
        r.cls    = cls;
        r.owned  = owned;
        r.prior  = prior;
        r.lstart = lstart;
        r.lend   = lend;
        r.rel    = rel;
        return r;
    endfunction

    function spill_req_t random_request();
        spill_req_t r;
        int sel;
        int c;
        r.cls    = $urandom_range(0, 1);
        r.owned  = ($urandom_range(0, 9) == 0);
        r.prior  = $urandom_range(0, 63);
        r.lstart = $urandom_range(0, 65535);
        r.lend   = $urandom_range(0, 65535);
        r.rel    = $urandom_range(0, 63);
        c = int'(r.cls);
        sel = $urandom_range(0, 99);
        if (sel < 3)
            r.kind = KIND_SPARE;
        else if (sel < 18)
            r.kind = KIND_FIXED;
        else if (sel < 38)
        begin
            r.kind = KIND_RELEASE;
            if (sb.fill[c] > 0 && $urandom_range(0, 1) == 1)
                r.rel = $urandom_range(0, sb.fill[c] - 1);
        end
        else
        begin
            r.kind = KIND_REUSE;
            // mostly intervals that move forward like a linear scan; some noise
            if ($urandom_range(0, 9) != 0)
            begin
                pc_cursor[c] = pc_cursor[c] + LIVE_W'($urandom_range(0, 40));
                r.lstart = pc_cursor[c];
                r.lend   = r.lstart + LIVE_W'($urandom_range(1, 300));
            end
        end
        return r;
    endfunction

    task automatic drive_request(spill_req_t r);
        int gap;
        gap = idle_gap(src_mode);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.rel, r.lend, r.lstart, r.prior, r.owned};
        s_tuser  <= {r.cls, r.kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(r);
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_grant(m_tdata, m_tuser);
    end

    initial
    begin : sink
        int  stall_left;
        int  span_left;
        int  hold_left;
        int  mode;
        bit  held;
        stall_left = 0;
        span_left  = 0;
        hold_left  = 0;
        mode       = 0;
        held       = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && requests_sent >= SINK_HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = SINK_HOLD_LEN;
            end
            if (span_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                span_left = $urandom_range(100, 400);
            end
            else
                span_left--;
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall_left = idle_gap(mode);
                m_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin
        spill_req_t directed[$];
        int counted;
        int mode_left;
        spill_req_t r;

        sb = new();
        requests_sent = 0;
        src_mode      = 0;
        pc_cursor[0]  = '0;
        pc_cursor[1]  = '0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed = {directed, mk(KIND_REUSE, 1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 6'd0)};
        directed = {directed, mk(KIND_REUSE, 1'b0, 1'b0, 6'd0, 16'd0, 16'hFFFF, 6'd0)};
        directed = {directed, mk(KIND_FIXED, 1'b0, 1'b0, 6'd0, 16'hFFFF, 16'hFFFF, 6'd63)};
        directed = {directed, mk(KIND_REUSE, 1'b0, 1'b1, 6'd63, 16'hFFFF, 16'd0, 6'd63)};
        directed = {directed, mk(KIND_FIXED, 1'b1, 1'b1, 6'd0, 16'd0, 16'd0, 6'd0)};
        directed = {directed, mk(KIND_REUSE, 1'b0, 1'b0, 6'd0, 16'd100, 16'd200, 6'd0)};
        directed = {directed, mk(KIND_RELEASE, 1'b0, 1'b0, 6'd63, 16'hFFFF, 16'hFFFF, 6'd1)};
        directed = {directed, mk(KIND_REUSE, 1'b0, 1'b0, 6'd0, 16'd300, 16'd50, 6'd0)};
        directed = {directed, mk(KIND_RELEASE, 1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 6'd63)};
        directed = {directed, mk(KIND_SPARE, 1'b1, 1'b1, 6'd63, 16'hFFFF, 16'hFFFF, 6'd63)};
        directed = {directed, mk(KIND_SPARE, 1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 6'd0)};
        directed = {directed, mk(KIND_REUSE, 1'b1, 1'b0, 6'd0, 16'hFFFF, 16'hFFFF, 6'd0)};
        directed = {directed, mk(KIND_FIXED, 1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 6'd0)};
        directed = {directed, mk(KIND_REUSE, 1'b1, 1'b0, 6'd0, 16'd0, 16'd1, 6'd0)};
        directed = {directed, mk(KIND_RELEASE, 1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 6'd0)};
        directed = {directed, mk(KIND_RELEASE, 1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 6'd5)};
        directed = {directed, mk(KIND_REUSE, 1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 6'd0)};
        directed = {directed, mk(KIND_RELEASE, 1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 6'd1)};
        directed = {directed, mk(KIND_REUSE, 1'b1, 1'b0, 6'd0, 16'd0, 16'hFFFF, 6'd0)};
        directed = {directed, mk(KIND_REUSE, 1'b0, 1'b0, 6'd0, 16'hFFFF, 16'hFFFE, 6'd0)};
        directed = {directed, mk(KIND_FIXED, 1'b0, 1'b1, 6'd42, 16'd0, 16'd0, 6'd0)};
        foreach (directed[i])
            drive_request(directed[i]);

        counted   = 0;
        mode_left = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if (mode_left == 0)
            begin
                src_mode  = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 200);
            end
            else
                mode_left--;
            if (requests_sent == DRAIN_AT)
                wait_drained();
            r = random_request();
            drive_request(r);
            if (r.kind != KIND_SPARE)
                counted++;
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d appends, %0d first-fit reuses, %0d table-full",
                 requests_sent, sb.n_appended, sb.n_reused, sb.n_full);
        $display("summary: %0d owned returns, %0d releases, %0d mismatches",
                 sb.n_owned, sb.n_released, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
